[rtl/cmrxq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmrxq_pkg
// Types and codes shared by the mailbox receive queue block: command and
// status codes, the command word, the result word and the stored frame.
// ----------------------------------------------------------------------------
package cmrxq_pkg;

  // command codes
  typedef enum logic [2:0] {
    CMD_PUSH      = 3'd0,
    CMD_POP       = 3'd1,
    CMD_CLEAR     = 3'd2,
    CMD_OPEN      = 3'd3,
    CMD_CLOSE     = 3'd4,
    CMD_CLOSE_ALL = 3'd5
  } cmd_e;

  // status codes
  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_INVALID = 3'd3,
    ST_CLOSED  = 3'd4
  } status_e;

  // one command word
  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  mailbox;
    logic [28:0] frame_ident;
    logic        frame_extended;
    logic        frame_remote;
    logic [3:0]  frame_length;
    logic [63:0] frame_payload;
  } cmd_word_t;

  // one result word
  typedef struct packed {
    logic [2:0]  status;
    logic [28:0] out_ident;
    logic        out_extended;
    logic        out_remote;
    logic [3:0]  out_length;
    logic [63:0] out_payload;
  } result_word_t;

  // one stored frame
  typedef struct packed {
    logic [28:0] ident;
    logic        extended;
    logic        remote;
    logic [3:0]  length;
    logic [63:0] payload;
  } frame_t;

endpackage
`default_nettype wire

[rtl/cmrxq_frame_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmrxq_frame_ram
// Frame store for all queues: one write port, one read port, registered
// read data, no reset on the contents.
// ----------------------------------------------------------------------------
module cmrxq_frame_ram
  import cmrxq_pkg::*;
#(
  parameter int unsigned DEPTH = 112
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire frame_t                   wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output frame_t                        rdata_o
);

  frame_t mem_q [DEPTH];
  frame_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/can_mailbox_rx_queues_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_mailbox_rx_queues_core
// Receive ring queues, one per mailbox, with push, pop, clear, open, close
// and close-all commands. Frames live in one shared frame memory; the write
// index, read index and open flag of each mailbox live in flip-flops.
//
//   channel   ports                        direction  handshake
//   command   start_i, busy_o, cmd_word_i  in         start_i && !busy_o
//   result    done_o, result_o             out        done_o, one cycle
//
// One command per cycle; each result appears in the cycle after its command,
// as the read of the frame memory is registered. Indices are
// updated in the accept cycle, so back-to-back commands see each other.
// busy_o stays low. Reset clears indices and open flags at once; the frame
// memory is not cleared and needs no clearing pass. The receiver cannot
// stall, so no result is ever held.
// ----------------------------------------------------------------------------
module can_mailbox_rx_queues_core
  import cmrxq_pkg::*;
#(
  parameter int unsigned QUEUE_SLOTS   = 16,
  parameter int unsigned MAILBOX_COUNT = 7
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  output logic              busy_o,
  input  wire cmd_word_t    cmd_word_i,
  output logic              done_o,
  output result_word_t      result_o
);

  localparam int unsigned IDX_W  = $clog2(QUEUE_SLOTS);
  localparam int unsigned MB_W   = (MAILBOX_COUNT > 1) ? $clog2(MAILBOX_COUNT) : 1;
  localparam int unsigned DEPTH  = MAILBOX_COUNT * QUEUE_SLOTS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [3:0]       MbLimit  = 4'(MAILBOX_COUNT);
  localparam logic [IDX_W-1:0] LastSlot = IDX_W'(QUEUE_SLOTS - 1);

  logic [IDX_W-1:0] wr_idx_q [MAILBOX_COUNT];
  logic [IDX_W-1:0] wr_idx_d [MAILBOX_COUNT];
  logic [IDX_W-1:0] rd_idx_q [MAILBOX_COUNT];
  logic [IDX_W-1:0] rd_idx_d [MAILBOX_COUNT];
  logic [MAILBOX_COUNT-1:0] open_q, open_d;

  logic             done_q, pop_ok_q, pop_ok_d;
  logic [2:0]       status_q, status_d;
  logic             accept;
  logic             mb_valid;
  logic [MB_W-1:0]  mb_idx;
  logic [IDX_W-1:0] cur_wr, cur_rd, nxt_wr, nxt_rd;
  logic [ADDR_W-1:0] base_addr;
  logic             mem_we, mem_re;
  frame_t           wr_frame, rd_frame;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // mailbox decode and queue pointers
  assign mb_valid  = {1'b0, cmd_word_i.mailbox} < MbLimit;
  assign mb_idx    = cmd_word_i.mailbox[MB_W-1:0];
  assign cur_wr    = wr_idx_q[mb_idx];
  assign cur_rd    = rd_idx_q[mb_idx];
  assign nxt_wr    = (cur_wr == LastSlot) ? '0 : cur_wr + 1'b1;
  assign nxt_rd    = (cur_rd == LastSlot) ? '0 : cur_rd + 1'b1;
  assign base_addr = ADDR_W'(mb_idx) * ADDR_W'(QUEUE_SLOTS);

  assign wr_frame.ident    = cmd_word_i.frame_ident;
  assign wr_frame.extended = cmd_word_i.frame_extended;
  assign wr_frame.remote   = cmd_word_i.frame_remote;
  assign wr_frame.length   = cmd_word_i.frame_length;
  assign wr_frame.payload  = cmd_word_i.frame_payload;

  // command execution
  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    open_d   = open_q;
    status_d = ST_DONE;
    pop_ok_d = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    if (accept) begin
      unique case (cmd_word_i.cmd)
        CMD_CLOSE_ALL: begin
          open_d = '0;
          for (int i = 0; i < MAILBOX_COUNT; i++) begin
            wr_idx_d[i] = '0;
            rd_idx_d[i] = '0;
          end
        end
        CMD_PUSH, CMD_POP, CMD_CLEAR, CMD_OPEN, CMD_CLOSE: begin
          if (!mb_valid) begin
            status_d = ST_INVALID;
          end else begin
            unique case (cmd_word_i.cmd)
              CMD_PUSH: begin
                if (!open_q[mb_idx]) begin
                  status_d = ST_CLOSED;
                end else if (nxt_wr == cur_rd) begin
                  status_d = ST_FULL;
                end else begin
                  mem_we           = 1'b1;
                  wr_idx_d[mb_idx] = nxt_wr;
                end
              end
              CMD_POP: begin
                if (cur_rd == cur_wr) begin
                  status_d = ST_EMPTY;
                end else begin
                  mem_re           = 1'b1;
                  pop_ok_d         = 1'b1;
                  rd_idx_d[mb_idx] = nxt_rd;
                end
              end
              CMD_OPEN: begin
                wr_idx_d[mb_idx] = '0;
                rd_idx_d[mb_idx] = '0;
                open_d[mb_idx]   = 1'b1;
              end
              CMD_CLOSE: begin
                wr_idx_d[mb_idx] = '0;
                rd_idx_d[mb_idx] = '0;
                open_d[mb_idx]   = 1'b0;
              end
              default: begin
                wr_idx_d[mb_idx] = '0;
                rd_idx_d[mb_idx] = '0;
              end
            endcase
          end
        end
        default: begin
          status_d = ST_DONE;
        end
      endcase
    end
  end

  // queue state and result control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAILBOX_COUNT; i++) begin
        wr_idx_q[i] <= '0;
        rd_idx_q[i] <= '0;
      end
      open_q   <= '0;
      done_q   <= 1'b0;
      pop_ok_q <= 1'b0;
      status_q <= ST_DONE;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      open_q   <= open_d;
      done_q   <= accept;
      pop_ok_q <= pop_ok_d;
      status_q <= status_d;
    end
  end

  // frame memory
  cmrxq_frame_ram #(
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (base_addr + ADDR_W'(cur_wr)),
    .wdata_i (wr_frame),
    .re_i    (mem_re),
    .raddr_i (base_addr + ADDR_W'(cur_rd)),
    .rdata_o (rd_frame)
  );

  // result word, frame fields zero unless a pop succeeded
  assign done_o                = done_q;
  assign result_o.status       = status_q;
  assign result_o.out_ident    = pop_ok_q ? rd_frame.ident    : '0;
  assign result_o.out_extended = pop_ok_q ? rd_frame.extended : 1'b0;
  assign result_o.out_remote   = pop_ok_q ? rd_frame.remote   : 1'b0;
  assign result_o.out_length   = pop_ok_q ? rd_frame.length   : '0;
  assign result_o.out_payload  = pop_ok_q ? rd_frame.payload  : '0;

endmodule
`default_nettype wire

[rtl/cmrxq_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmrxq_checker
// Port-level checks on the mailbox receive queue block, bound to the top.
// ----------------------------------------------------------------------------
module cmrxq_checker
  import cmrxq_pkg::*;
(
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         start_i,
  input wire logic         busy_o,
  input wire cmd_word_t    cmd_word_i,
  input wire logic         done_o,
  input wire result_word_t result_o
);

  // every accepted word answers in the next cycle
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("accepted word got no result");

  // no result without an accepted word
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result without command");

  // frame fields are zero unless the pop succeeded
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != ST_DONE) |->
      (result_o.out_ident == '0 && result_o.out_payload == '0 &&
       result_o.out_length == '0 && !result_o.out_extended && !result_o.out_remote))
    else $error("frame fields set on failed command");

  // a non-pop command never returns frame data
  a_nonpop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_word_i.cmd != CMD_POP) |=>
      (result_o.out_payload == '0 && result_o.out_ident == '0))
    else $error("frame data on non-pop command");

endmodule

bind can_mailbox_rx_queues_core cmrxq_checker u_cmrxq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .cmd_word_i (cmd_word_i),
  .done_o     (done_o),
  .result_o   (result_o)
);
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mailbox receive queue block. Command words are
// driven with random gaps. A local queue predictor tracks indices, open flags
// and stored frames, and every result word is compared field by field with
// the oldest predicted word.
// ----------------------------------------------------------------------------
module tb_top;
  import cmrxq_pkg::*;

  localparam int SLOTS       = 16;
  localparam int MBOX_N      = 7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_ITEMS  = 890;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam logic [2:0] MB_INVALID  = 3'd7;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         start_i = 1'b0;
  logic         busy_o;
  cmd_word_t    cmd_word_i = '0;
  logic         done_o;
  result_word_t result_o;

  // predictor state
  int           wr_slot [MBOX_N];
  int           rd_slot [MBOX_N];
  bit           mb_open [MBOX_N];
  frame_t       frame_mem [MBOX_N][SLOTS];
  result_word_t pending_results [$];

  int  err_cnt   = 0;
  int  cycle_cnt = 0;
  bit  idle_en   = 1'b1;

  can_mailbox_rx_queues_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .cmd_word_i (cmd_word_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // queue predictor: one command word in, its result word out
  function automatic result_word_t mailbox_step(cmd_word_t w);
    result_word_t r;
    int           nxt;
    int           mb;
    frame_t       f;
    r        = '0;
    r.status = ST_DONE;
    mb       = int'(w.mailbox);
    if (w.cmd == CMD_CLOSE_ALL) begin
      for (int i = 0; i < MBOX_N; i++) begin
        mb_open[i] = 1'b0;
        wr_slot[i] = 0;
        rd_slot[i] = 0;
      end
    end else if (w.cmd > CMD_CLOSE_ALL) begin
      // spare codes leave everything alone
    end else if (mb >= MBOX_N) begin
      r.status = ST_INVALID;
    end else begin
      case (w.cmd)
        CMD_PUSH: begin
          nxt = (wr_slot[mb] + 1) % SLOTS;
          if (!mb_open[mb]) begin
            r.status = ST_CLOSED;
          end else if (nxt == rd_slot[mb]) begin
            r.status = ST_FULL;
          end else begin
            f.ident    = w.frame_ident;
            f.extended = w.frame_extended;
            f.remote   = w.frame_remote;
            f.length   = w.frame_length;
            f.payload  = w.frame_payload;
            frame_mem[mb][wr_slot[mb]] = f;
            wr_slot[mb] = nxt;
          end
        end
        CMD_POP: begin
          if (rd_slot[mb] == wr_slot[mb]) begin
            r.status = ST_EMPTY;
          end else begin
            f              = frame_mem[mb][rd_slot[mb]];
            r.out_ident    = f.ident;
            r.out_extended = f.extended;
            r.out_remote   = f.remote;
            r.out_length   = f.length;
            r.out_payload  = f.payload;
            rd_slot[mb]    = (rd_slot[mb] + 1) % SLOTS;
          end
        end
        default: begin
          // clear, open and close rewind the queue
          wr_slot[mb] = 0;
          rd_slot[mb] = 0;
          if (w.cmd == CMD_OPEN) mb_open[mb] = 1'b1;
          if (w.cmd == CMD_CLOSE) mb_open[mb] = 1'b0;
        end
      endcase
    end
    return r;
  endfunction

  // command word with random frame content
  function automatic cmd_word_t make_word(logic [2:0] cmd, logic [2:0] mb);
    cmd_word_t w;
    w.cmd            = cmd;
    w.mailbox        = mb;
    w.frame_ident    = 29'($urandom);
    w.frame_extended = 1'($urandom);
    w.frame_remote   = 1'($urandom);
    w.frame_length   = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                   : 4'($urandom_range(0, 8));
    w.frame_payload  = {$urandom, $urandom};
    return w;
  endfunction

  // drive one command word and wait until it is taken
  task automatic send_word(cmd_word_t w);
    @(negedge clk_i);
    while (idle_en && $urandom_range(0, 99) < 33) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i    <= 1'b1;
    cmd_word_i <= w;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(mailbox_step(w));
  endtask

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    result_word_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result word, expected none actual %h", $time, result_o);
      end else begin
        want = pending_results.pop_front();
        compare_field("status",   64'(want.status),       64'(result_o.status));
        compare_field("ident",    64'(want.out_ident),    64'(result_o.out_ident));
        compare_field("extended", 64'(want.out_extended), 64'(result_o.out_extended));
        compare_field("remote",   64'(want.out_remote),   64'(result_o.out_remote));
        compare_field("length",   64'(want.out_length),   64'(result_o.out_length));
        compare_field("payload",  want.out_payload,       result_o.out_payload);
      end
    end
  end

  // edge cases: closed and invalid mailboxes, spare codes, field extremes
  task automatic test_directed();
    cmd_word_t w;
    send_word(make_word(CMD_POP, 3'd0));
    send_word(make_word(CMD_PUSH, 3'd0));
    send_word(make_word(CMD_PUSH, MB_INVALID));
    send_word(make_word(CMD_POP, MB_INVALID));
    send_word(make_word(CMD_CLEAR, MB_INVALID));
    send_word(make_word(CMD_OPEN, MB_INVALID));
    send_word(make_word(CMD_CLOSE, MB_INVALID));
    send_word(make_word(CMD_SPARE_6, 3'd0));
    send_word(make_word(CMD_SPARE_7, MB_INVALID));
    send_word(make_word(CMD_OPEN, 3'd0));
    // all-ones frame, then all-zeros frame
    w = '1;
    w.cmd     = CMD_PUSH;
    w.mailbox = 3'd0;
    send_word(w);
    w = '0;
    w.cmd     = CMD_PUSH;
    w.mailbox = 3'd0;
    send_word(w);
    send_word(make_word(CMD_POP, 3'd0));
    send_word(make_word(CMD_POP, 3'd0));
    send_word(make_word(CMD_POP, 3'd0));
    // reopen and clear drop queued frames
    send_word(make_word(CMD_OPEN, 3'd6));
    send_word(make_word(CMD_PUSH, 3'd6));
    send_word(make_word(CMD_OPEN, 3'd6));
    send_word(make_word(CMD_POP, 3'd6));
    send_word(make_word(CMD_PUSH, 3'd6));
    send_word(make_word(CMD_CLEAR, 3'd6));
    send_word(make_word(CMD_POP, 3'd6));
    // close all ignores the mailbox field
    send_word(make_word(CMD_PUSH, 3'd6));
    send_word(make_word(CMD_CLOSE_ALL, MB_INVALID));
    send_word(make_word(CMD_POP, 3'd6));
    send_word(make_word(CMD_PUSH, 3'd6));
    send_word(make_word(CMD_CLOSE, 3'd0));
  endtask

  // fill one queue to the drop point, drain it, then wrap the indices
  task automatic test_fill_queue();
    send_word(make_word(CMD_OPEN, 3'd3));
    repeat (SLOTS) send_word(make_word(CMD_PUSH, 3'd3));
    repeat (SLOTS) send_word(make_word(CMD_POP, 3'd3));
    repeat (5) send_word(make_word(CMD_PUSH, 3'd3));
    repeat (5) send_word(make_word(CMD_POP, 3'd3));
  endtask

  // mostly push and pop traffic on open mailboxes, some noise
  task automatic test_random(int n_items);
    int         push_pct;
    int         hot_max;
    int         pick;
    logic [2:0] cmd;
    logic [2:0] mb;
    for (int i = 0; i < MBOX_N; i++) send_word(make_word(CMD_OPEN, 3'(i)));
    for (int n = 0; n < n_items; n++) begin
      // new traffic mix every 100 words
      if (n % 100 == 0) begin
        push_pct = $urandom_range(25, 75);
        hot_max  = $urandom_range(0, MBOX_N - 1);
      end
      idle_en = !(n >= 300 && n < 550);
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
      end else if (pick < 91) begin
        cmd = CMD_CLEAR;
      end else if (pick < 95) begin
        cmd = CMD_OPEN;
      end else if (pick < 97) begin
        cmd = CMD_CLOSE;
      end else if (pick < 98) begin
        cmd = CMD_CLOSE_ALL;
      end else begin
        cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
      end
      mb = ($urandom_range(0, 99) < 4) ? MB_INVALID : 3'($urandom_range(0, hot_max));
      send_word(make_word(cmd, mb));
    end
    idle_en = 1'b1;
  endtask

  // test sequence
  initial begin
    for (int i = 0; i < MBOX_N; i++) begin
      wr_slot[i] = 0;
      rd_slot[i] = 0;
      mb_open[i] = 1'b0;
      for (int s = 0; s < SLOTS; s++) frame_mem[i][s] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_fill_queue();
    test_random(RAND_ITEMS);

    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
